// ----- rtl/csb_pkg.sv -----
// ----------------------------------------------------------------------------
// csb_pkg
// shared types and constants of the counting semaphore bank
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int ACTION_W      = 1;
    localparam int SEM_INDEX_W   = 3;
    localparam int TASK_FIELD_W  = 6;
    localparam int COUNT_W       = 8;
    localparam int INIT_W        = 7;
    localparam int MAX_BANK      = 1 << SEM_INDEX_W;

    localparam logic [ACTION_W-1:0] ACT_WAIT   = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_SIGNAL = 1'b1;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd128;

    // operation handed from the front end to the back end
    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic                    in_range;
        logic [SEM_INDEX_W-1:0]  sem_index;
        logic [TASK_FIELD_W-1:0] caller_task;
    } t_op;

    // one result transaction
    typedef struct packed {
        logic                       caller_blocked;
        logic                       woken_valid;
        logic [TASK_FIELD_W-1:0]    woken_task;
        logic signed [COUNT_W-1:0]  count_after;
        logic                       queue_overflow;
    } t_result;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

// ----- rtl/counting_semaphore_bank.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_bank
// bank of counting semaphores, each with a fifo ring of waiting task ids
// ----------------------------------------------------------------------------
// Each accepted transaction (wait or signal on one semaphore) yields exactly
// one result transaction. The back end's idle state pops an operation,
// updates the count and ring pointers and accesses the wait-ring ram; its
// emit state moves the ram read data into the output register. A two-entry
// queue in front lets new operations be accepted while the back end works or
// the output stalls. A config write loads every count with the written value
// and empties every ring; write it only while idle.
// ----------------------------------------------------------------------------
module counting_semaphore_bank
    import csb_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 8,
    parameter int QUEUE_SLOTS    = 8,
    parameter int TASK_ID_BITS   = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,     // initial_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sem_index, caller_task
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // caller_blocked, woken_valid, woken_task,
                                        // count_after, queue_overflow
);

    logic    w_op_valid;
    t_op     w_op;
    logic    w_op_pop;
    t_result w_out;

    assign o_cfg_ready = 1'b1;

    csb_front #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_sem_index   (s_axis_tdata[2:0]),
        .i_caller_task (s_axis_tdata[8:3]),
        .o_op_valid    (w_op_valid),
        .o_op          (w_op),
        .i_op_pop      (w_op_pop)
    );

    csb_back #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_SLOTS    (QUEUE_SLOTS),
        .TASK_ID_BITS   (TASK_ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_op_valid  (w_op_valid),
        .i_op        (w_op),
        .o_op_pop    (w_op_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tdata = {7'd0, w_out.queue_overflow, w_out.count_after,
                           w_out.woken_task, w_out.woken_valid, w_out.caller_blocked};

    a_full_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_op_valid)
        else $error("input stalled with empty operation queue");

    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op_pop |=> !w_op_pop)
        else $error("back end took operations in consecutive cycles");

    a_wake_only_on_signal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (!m_axis_tdata[0] && !m_axis_tdata[16]))
        else $error("wake reported together with a blocking result");

endmodule

// ----- rtl/csb_ram.sv -----
// ----------------------------------------------------------------------------
// csb_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module csb_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/csb_front.sv -----
// ----------------------------------------------------------------------------
// csb_front
// accepts operations, checks the semaphore index and queues them
// ----------------------------------------------------------------------------
module csb_front
    import csb_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ACTION_W-1:0]     i_action,
    input  logic [SEM_INDEX_W-1:0]  i_sem_index,
    input  logic [TASK_FIELD_W-1:0] i_caller_task,
    output logic                    o_op_valid,
    output t_op                     o_op,
    input  logic                    i_op_pop
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_fill;
    logic       w_push;
    logic       w_pop;
    t_op        w_op;

    // classify
    always_comb begin
        w_op.action      = i_action;
        w_op.in_range    = (7'(i_sem_index) < 7'(NUM_SEMAPHORES));
        w_op.sem_index   = i_sem_index;
        w_op.caller_task = i_caller_task;
    end

    assign o_ready    = (r_fill != 2'd2);
    assign w_push     = i_valid && o_ready;
    assign o_op_valid = (r_fill != 2'd0);
    assign w_pop      = i_op_pop && o_op_valid;
    assign o_op       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_op;
        end
    end

endmodule

// ----- rtl/csb_back.sv -----
// ----------------------------------------------------------------------------
// csb_back
// executes queued operations on counts and wait rings, holds the result
// ----------------------------------------------------------------------------
module csb_back
    import csb_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 8,
    parameter int QUEUE_SLOTS    = 8,
    parameter int TASK_ID_BITS   = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [INIT_W-1:0] i_cfg_data,
    input  logic              i_op_valid,
    input  t_op               i_op,
    output logic              o_op_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out
);

    localparam int NS  = (NUM_SEMAPHORES < MAX_BANK) ? NUM_SEMAPHORES : MAX_BANK;
    localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
    localparam int QW  = $clog2(QUEUE_SLOTS);
    localparam int TW  = (TASK_ID_BITS < TASK_FIELD_W) ? TASK_ID_BITS : TASK_FIELD_W;
    localparam int RD  = NS * QUEUE_SLOTS;
    localparam int RAW = $clog2(RD);

    logic signed [COUNT_W-1:0] r_count [NS];
    logic [QW-1:0]             r_head  [NS];
    logic [QW-1:0]             r_tail  [NS];

    t_back_state r_state;
    t_back_state n_state;
    t_result     r_pend;
    t_result     r_out;
    logic        r_out_valid;
    logic        w_load;

    logic [SW-1:0]             w_sidx;
    logic signed [COUNT_W-1:0] w_cnt;
    logic signed [COUNT_W-1:0] w_cnt_new;
    logic [QW-1:0]             w_head;
    logic [QW-1:0]             w_tail;
    logic [QW-1:0]             w_head_nx;
    logic [QW-1:0]             w_tail_nx;
    logic                      w_blocked;
    logic                      w_overflow;
    logic                      w_wake;
    logic [RAW-1:0]            w_base;
    logic [TW-1:0]             w_rdata;
    t_result                   w_res;

    assign w_sidx    = i_op.in_range ? i_op.sem_index[SW-1:0] : '0;
    assign w_cnt     = r_count[w_sidx];
    assign w_head    = r_head[w_sidx];
    assign w_tail    = r_tail[w_sidx];
    assign w_head_nx = (w_head == QW'(QUEUE_SLOTS - 1)) ? '0 : w_head + QW'(1);
    assign w_tail_nx = (w_tail == QW'(QUEUE_SLOTS - 1)) ? '0 : w_tail + QW'(1);
    assign w_base    = RAW'(RAW'(w_sidx) * RAW'(QUEUE_SLOTS));

    always_comb begin
        w_cnt_new  = w_cnt;
        w_blocked  = 1'b0;
        w_overflow = 1'b0;
        w_wake     = 1'b0;
        if (i_op.action == ACT_WAIT) begin
            if (w_cnt != COUNT_MIN) begin
                w_cnt_new = w_cnt - 8'sd1;
            end
            if (w_cnt_new < 0) begin
                if (w_tail_nx == w_head) begin
                    w_overflow = 1'b1;
                end else begin
                    w_blocked = 1'b1;
                end
            end
        end else begin
            if (w_cnt != COUNT_MAX) begin
                w_cnt_new = w_cnt + 8'sd1;
            end
            if (w_cnt_new <= 0 && w_head != w_tail) begin
                w_wake = 1'b1;
            end
        end
        if (!i_op.in_range) begin
            w_blocked  = 1'b0;
            w_overflow = 1'b0;
            w_wake     = 1'b0;
        end
        w_res.caller_blocked = w_blocked;
        w_res.woken_valid    = w_wake;
        w_res.woken_task     = '0;
        w_res.count_after    = i_op.in_range ? w_cnt_new : '0;
        w_res.queue_overflow = w_overflow;
    end

    csb_ram #(
        .WIDTH (TW),
        .DEPTH (RD)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (o_op_pop && w_blocked),
        .i_waddr (w_base + RAW'(w_tail)),
        .i_wdata (i_op.caller_task[TW-1:0]),
        .i_re    (o_op_pop && w_wake),
        .i_raddr (w_base + RAW'(w_head)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_op_pop = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_op_valid) begin
                    o_op_pop = 1'b1;
                    n_state  = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < NS; i++) begin
                r_count[i] <= COUNT_W'(i_cfg_data);
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
            end
        end else if (o_op_pop && i_op.in_range) begin
            r_count[w_sidx] <= w_cnt_new;
            if (w_blocked) begin
                r_tail[w_sidx] <= w_tail_nx;
            end
            if (w_wake) begin
                r_head[w_sidx] <= w_head_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_pend <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.caller_blocked <= r_pend.caller_blocked;
            r_out.woken_valid    <= r_pend.woken_valid;
            r_out.woken_task     <= r_pend.woken_valid ? TASK_FIELD_W'(w_rdata) : '0;
            r_out.count_after    <= r_pend.count_after;
            r_out.queue_overflow <= r_pend.queue_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- bench/counting_semaphore_bank_tb.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_bank_tb
// self-checking bench for the counting semaphore bank
// ----------------------------------------------------------------------------
// A table of directed operations comes first. It covers a wait and a signal
// right after reset, the widest task ids and semaphore indexes, a signal on
// an empty ring, and a ring that fills up and then drops a waiter. It also
// covers count saturation at the top and the clearing of counts and rings
// when the starting count is written. After that, random phases run under
// several starting counts, from 0 to 127. Some phases focus on one or a few
// semaphores, so the rings fill, wrap and drain and the count reaches its
// lower limit. A model in the bench predicts each result, but a checked
// directed row gives its own. Each result is compared field by field against
// the oldest expectation. Sends come in random bursts; the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module counting_semaphore_bank_tb;
    import csb_pkg::*;

    localparam int BANK_SIZE    = 8;
    localparam int RING_SLOTS   = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 100;

    typedef enum logic {
        ROW_OP,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        act;
        logic [2:0]  sem;
        logic [5:0]  caller;
        logic [6:0]  cfg_value;
        logic        chk;
        t_result     want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // sem_index, caller_task
    logic [0:0]  s_axis_tuser;     // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // caller_blocked, woken_valid, woken_task,
                                   // count_after, queue_overflow

    logic signed [7:0] model_count [BANK_SIZE];
    logic [5:0]        model_ring  [BANK_SIZE][RING_SLOTS];
    int                model_head  [BANK_SIZE];
    int                model_tail  [BANK_SIZE];

    t_result  expected_results [$];
    t_dir_row dir_rows [$];

    int mismatch_count = 0;
    int n_waits        = 0;
    int n_signals      = 0;
    int n_blocks       = 0;
    int n_wakeups      = 0;
    int n_overflows    = 0;
    int n_saturated    = 0;
    int n_cfg_writes   = 0;
    int burst_left     = 0;
    int gap_mode       = 1;
    int rx_mode        = 0;
    int rx_cycle       = 0;

    counting_semaphore_bank DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 300000);
        $display("Mismatches found");
        $finish;
    end

    task automatic load_model_bank(input logic [6:0] value);
        for (int s = 0; s < BANK_SIZE; s++) begin
            model_count[s] = $signed({1'b0, value});
            model_head[s]  = 0;
            model_tail[s]  = 0;
        end
    endtask

    function automatic t_result predict_semaphore_op(input logic act, input logic [2:0] sem,
                                                     input logic [5:0] caller);
        t_result           r;
        logic signed [7:0] c;
        int                nxt;
        r = '0;
        c = model_count[sem];
        if (act == ACT_WAIT) begin
            n_waits++;
            if (c > COUNT_MIN) c = c - 8'sd1;
            else n_saturated++;
            if (c < 0) begin
                nxt = (model_tail[sem] + 1) % RING_SLOTS;
                if (nxt == model_head[sem]) begin
                    r.queue_overflow = 1'b1;
                    n_overflows++;
                end else begin
                    model_ring[sem][model_tail[sem]] = caller;
                    model_tail[sem] = nxt;
                    r.caller_blocked = 1'b1;
                    n_blocks++;
                end
            end
        end else begin
            n_signals++;
            if (c < COUNT_MAX) c = c + 8'sd1;
            else n_saturated++;
            if (c <= 0 && model_head[sem] != model_tail[sem]) begin
                r.woken_valid = 1'b1;
                r.woken_task  = model_ring[sem][model_head[sem]];
                model_head[sem] = (model_head[sem] + 1) % RING_SLOTS;
                n_wakeups++;
            end
        end
        model_count[sem] = c;
        r.count_after = c;
        return r;
    endfunction

    function automatic t_dir_row op_row(input logic act, input logic [2:0] sem,
                                        input logic [5:0] caller, input logic chk,
                                        input logic blk, input logic wv,
                                        input logic [5:0] wt, input int cnt,
                                        input logic ovf);
        t_dir_row row;
        row.kind                = ROW_OP;
        row.act                 = act;
        row.sem                 = sem;
        row.caller              = caller;
        row.cfg_value           = '0;
        row.chk                 = chk;
        row.want.caller_blocked = blk;
        row.want.woken_valid    = wv;
        row.want.woken_task     = wt;
        row.want.count_after    = cnt[7:0];
        row.want.queue_overflow = ovf;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [6:0] value);
        t_dir_row row;
        row           = op_row(ACT_WAIT, 3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 6'd0, 0, 1'b0);
        row.kind      = ROW_CFG;
        row.cfg_value = value;
        return row;
    endfunction

    task automatic wait_for_drain();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_initial_count(input logic [6:0] value);
        wait_for_drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        load_model_bank(value);
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = 7'($urandom);
    endtask

    task automatic send_op(input logic act, input logic [2:0] sem, input logic [5:0] caller,
                           input logic chk, input t_result want);
        int      gap;
        t_result pred;
        if (burst_left == 0) begin
            gap = (gap_mode == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = 16'($urandom);
                s_axis_tuser  = 1'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, caller, sem};
        s_axis_tuser  = act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = predict_semaphore_op(act, sem, caller);
        expected_results.push_back(chk ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // receiver stall pattern
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = ($urandom_range(0, 99) < 55);
                default: m_axis_tready = ((rx_cycle % 9) < 5);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= PRINT_LIMIT)
                    $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("caller_blocked", want.caller_blocked, m_axis_tdata[0]);
                check_field("woken_valid", want.woken_valid, m_axis_tdata[1]);
                check_field("woken_task", want.woken_task, m_axis_tdata[7:2]);
                check_field("count_after", want.count_after, $signed(m_axis_tdata[15:8]));
                check_field("queue_overflow", want.queue_overflow, m_axis_tdata[16]);
                check_field("padding", 0, m_axis_tdata[23:17]);
            end
        end
    end

    initial begin
        int          n_items;
        int          wait_pct;
        int          focus;
        int          focus_base;
        logic [6:0]  init_value;
        logic        act;
        logic [2:0]  sem;
        t_result     none;

        none          = '0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 7'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = 1'b0;
        load_model_bank(7'd0);

        // count starts at zero after reset
        dir_rows.push_back(op_row(ACT_WAIT,   3'd0, 6'd63, 1, 1, 0, 6'd0,  -1, 0));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd0, 6'd0,  1, 0, 1, 6'd63,  0, 0));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd0, 6'd5,  1, 0, 0, 6'd0,   1, 0));
        dir_rows.push_back(op_row(ACT_WAIT,   3'd0, 6'd10, 1, 0, 0, 6'd0,   0, 0));
        // fill the ring of the top semaphore, then one more
        dir_rows.push_back(op_row(ACT_WAIT,   3'd7, 6'd0,  1, 1, 0, 6'd0,  -1, 0));
        for (int t = 1; t <= 6; t++)
            dir_rows.push_back(op_row(ACT_WAIT, 3'd7, 6'(t), 0, 0, 0, 6'd0, 0, 0));
        dir_rows.push_back(op_row(ACT_WAIT,   3'd7, 6'd42, 1, 0, 0, 6'd0,  -8, 1));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd7, 6'd9,  1, 0, 1, 6'd0,  -7, 0));
        dir_rows.push_back(op_row(ACT_WAIT,   3'd7, 6'd21, 0, 0, 0, 6'd0,   0, 0));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd7, 6'd1,  0, 0, 0, 6'd0,   0, 0));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd6, 6'd2,  0, 0, 0, 6'd0,   0, 0));
        // top of the count
        dir_rows.push_back(cfg_row(7'd127));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd3, 6'd63, 1, 0, 0, 6'd0, 127, 0));
        dir_rows.push_back(op_row(ACT_WAIT,   3'd3, 6'd0,  1, 0, 0, 6'd0, 126, 0));
        dir_rows.push_back(op_row(ACT_WAIT,   3'd5, 6'd33, 0, 0, 0, 6'd0,   0, 0));
        // rewrite clears every ring
        dir_rows.push_back(cfg_row(7'd0));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd2, 6'd7,  1, 0, 0, 6'd0,   1, 0));
        dir_rows.push_back(op_row(ACT_SIGNAL, 3'd7, 6'd7,  1, 0, 0, 6'd0,   1, 0));
        dir_rows.push_back(op_row(ACT_WAIT,   3'd4, 6'd63, 0, 0, 0, 6'd0,   0, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_initial_count(dir_rows[i].cfg_value);
            else
                send_op(dir_rows[i].act, dir_rows[i].sem, dir_rows[i].caller,
                        dir_rows[i].chk, dir_rows[i].want);
        end

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin init_value = 7'd0;   n_items = 170; wait_pct = 97; focus = 1; end
                1: begin init_value = 7'd127; n_items = 90;  wait_pct = 15; focus = 2; end
                2: begin init_value = 7'd1;   n_items = 110; wait_pct = 55; focus = 1; end
                3: begin
                    init_value = 7'($urandom_range(0, 127));
                    n_items = 100; wait_pct = 50; focus = 8;
                end
                4: begin init_value = 7'd0;   n_items = 110; wait_pct = 60; focus = 2; end
                5: begin
                    init_value = 7'($urandom_range(0, 5));
                    n_items = 100; wait_pct = 45; focus = 3;
                end
                default: begin init_value = 7'd0; n_items = 80; wait_pct = 50; focus = 8; end
            endcase
            write_initial_count(init_value);
            gap_mode   = ($urandom_range(0, 3) != 0);
            focus_base = $urandom_range(0, 7);
            for (int i = 0; i < n_items; i++) begin
                act = ($urandom_range(0, 99) < wait_pct) ? ACT_WAIT : ACT_SIGNAL;
                sem = 3'((focus_base + $urandom_range(0, focus - 1)) % BANK_SIZE);
                send_op(act, sem, 6'($urandom_range(0, 63)), 1'b0, none);
            end
        end

        wait_for_drain();
        $display("ran %0d waits and %0d signals over %0d starting-count writes",
                 n_waits, n_signals, n_cfg_writes);
        $display("saw %0d blocks, %0d wakeups, %0d ring overflows, %0d saturated steps",
                 n_blocks, n_wakeups, n_overflows, n_saturated);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
